[rtl/rrss_pkg.sv]
`default_nettype none

package rrss_pkg;

    localparam int DEF_MAX_PROCESSES = 16;
    localparam int DEF_BURST_BITS    = 16;

    localparam int QUANTUM_W  = 16;
    localparam int BURST_IN_W = 16;
    localparam int TIME_W     = 20;
    localparam int SUM_W      = 24;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd2;
    localparam logic [TIME_W-1:0]    TIME_MAX      = '1;
    localparam logic [SUM_W-1:0]     SUM_MAX       = '1;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RUN     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

    typedef struct packed {
        logic accept;
        logic scan;
        logic slice;
        logic advance;
        logic wait_t;
        logic turn;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic exhausted;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[rtl/rrss_ram.sv]
`default_nettype none

module rrss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/rrss_ctrl.sv]
`default_nettype none

module rrss_ctrl import rrss_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [OP_W-1:0] i_operation,
    input  wire t_stat           i_stat,
    output logic                 o_in_stall,
    output t_cmd                 o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_SLICE   = 3'd2;
    localparam logic [2:0] S_ADVANCE = 3'd3;
    localparam logic [2:0] S_WAIT_T  = 3'd4;
    localparam logic [2:0] S_TURN    = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_operation == OP_STEP) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.found) begin
                    n_state = S_SLICE;
                end else if (i_stat.exhausted) begin
                    n_state = S_EMIT;
                end
            end
            S_SLICE: begin
                o_cmd.slice = 1'b1;
                n_state = S_ADVANCE;
            end
            S_ADVANCE: begin
                o_cmd.advance = 1'b1;
                n_state = S_WAIT_T;
            end
            S_WAIT_T: begin
                o_cmd.wait_t = 1'b1;
                n_state = S_TURN;
            end
            S_TURN: begin
                o_cmd.turn = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register can take the word
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/rrss_datapath.sv]
`default_nettype none

module rrss_datapath import rrss_pkg::*; #(
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
    parameter int BURST_BITS    = DEF_BURST_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [QUANTUM_W-1:0]             i_cfg_wr_data,
    input  wire logic [OP_W-1:0]                  i_operation,
    input  wire logic [BURST_IN_W-1:0]            i_burst_len,
    input  wire t_cmd                             i_cmd,
    output t_stat                                 o_stat,
    input  wire logic                             i_out_stall,
    output logic                                  o_out_valid,
    output logic [STATUS_W-1:0]                   o_status,
    output logic [$clog2(MAX_PROCESSES)-1:0]      o_process_index,
    output logic [TIME_W-1:0]                     o_slice_end_time,
    output logic                                  o_finished,
    output logic [TIME_W-1:0]                     o_waiting_time,
    output logic [TIME_W-1:0]                     o_turnaround_time,
    output logic [SUM_W-1:0]                      o_total_waiting,
    output logic [SUM_W-1:0]                      o_total_turnaround
);

    localparam int IW  = $clog2(MAX_PROCESSES);
    localparam int CW  = $clog2(MAX_PROCESSES + 1);
    localparam int BW  = BURST_BITS;
    localparam int SW  = (BW > QUANTUM_W) ? BW : QUANTUM_W;
    localparam int TW  = ((SW > TIME_W) ? SW : TIME_W) + 1;
    localparam int WW  = (BW > TIME_W) ? BW : TIME_W;
    localparam int UW  = WW + 1;
    localparam int S1W = SUM_W + 1;

    // architectural state
    logic [QUANTUM_W-1:0] r_quantum;
    logic [CW-1:0]        r_count;
    logic [TIME_W-1:0]    r_time;
    logic [IW-1:0]        r_sp;
    logic [SUM_W-1:0]     r_wsum;
    logic [SUM_W-1:0]     r_tsum;

    // per-item working registers
    logic [OP_W-1:0]      r_op;
    logic [BW-1:0]        r_burst_in;
    logic [IW-1:0]        r_addr;
    logic [CW-1:0]        r_left;
    logic                 r_chk_v;
    logic [IW-1:0]        r_chk_idx;
    logic                 r_found;
    logic [IW-1:0]        r_sel;
    logic [BW-1:0]        r_rem;
    logic [BW-1:0]        r_bur;
    logic [SW-1:0]        r_slice;
    logic                 r_fin;
    logic [TIME_W-1:0]    r_wt;
    logic [TIME_W-1:0]    r_tat;

    // output word
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [IW-1:0]        r_out_index;
    logic [TIME_W-1:0]    r_out_time;
    logic                 r_out_fin;
    logic [TIME_W-1:0]    r_out_wt;
    logic [TIME_W-1:0]    r_out_tat;
    logic [SUM_W-1:0]     r_out_wsum;
    logic [SUM_W-1:0]     r_out_tsum;

    logic [STATUS_W-1:0]  n_out_status;
    logic [IW-1:0]        n_out_index;
    logic [TIME_W-1:0]    n_out_time;
    logic                 n_out_fin;
    logic [TIME_W-1:0]    n_out_wt;
    logic [TIME_W-1:0]    n_out_tat;
    logic [SUM_W-1:0]     n_out_wsum;
    logic [SUM_W-1:0]     n_out_tsum;

    logic [BW-1:0]        rd_rem;
    logic [BW-1:0]        rd_bur;
    logic                 issue;
    logic                 table_full;
    logic [IW-1:0]        count_idx;
    logic                 load_we;
    logic                 rem_we;
    logic [IW-1:0]        rem_waddr;
    logic [BW-1:0]        rem_wdata;
    logic [IW-1:0]        addr_next;
    logic [IW-1:0]        scan_start;
    logic [SW-1:0]        q_eff;
    logic                 rem_gt;
    logic [BW-1:0]        new_rem;
    logic [TW-1:0]        time_sum;
    logic [TIME_W-1:0]    time_sat;
    logic [IW-1:0]        sp_next;
    logic [TIME_W-1:0]    wt_next;
    logic [UW-1:0]        tat_sum;
    logic [TIME_W-1:0]    tat_next;
    logic [S1W-1:0]       wsum_add;
    logic [S1W-1:0]       tsum_add;
    logic [SUM_W-1:0]     wsum_next;
    logic [SUM_W-1:0]     tsum_next;

    assign issue      = i_cmd.scan && (r_left != '0);
    assign table_full = (r_count >= CW'(MAX_PROCESSES));
    assign count_idx  = r_count[IW-1:0];
    assign load_we    = i_cmd.emit && (r_op == OP_LOAD) && !table_full;
    assign rem_we     = load_we || i_cmd.slice;
    assign rem_waddr  = i_cmd.slice ? r_sel : count_idx;
    assign rem_wdata  = i_cmd.slice ? new_rem : r_burst_in;

    rrss_ram #(.WIDTH(BW), .DEPTH(MAX_PROCESSES)) u_remaining (
        .i_clk     (i_clk),
        .i_wr_en   (rem_we),
        .i_wr_addr (rem_waddr),
        .i_wr_data (rem_wdata),
        .i_rd_en   (issue),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_rem)
    );

    rrss_ram #(.WIDTH(BW), .DEPTH(MAX_PROCESSES)) u_burst (
        .i_clk     (i_clk),
        .i_wr_en   (load_we),
        .i_wr_addr (count_idx),
        .i_wr_data (r_burst_in),
        .i_rd_en   (issue),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_bur)
    );

    assign o_stat.found     = r_chk_v && (rd_rem != '0);
    assign o_stat.exhausted = !r_chk_v && (r_left == '0);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    // scan walks the table cyclically and wraps at the fill count
    assign addr_next  = ((CW'(r_addr) + CW'(1)) == r_count) ? '0 : r_addr + IW'(1);
    assign scan_start = ((r_count != '0) && (CW'(r_sp) < r_count)) ? r_sp : '0;

    assign q_eff   = (r_quantum == '0) ? SW'(1) : SW'(r_quantum);
    assign rem_gt  = SW'(r_rem) > q_eff;
    assign new_rem = rem_gt ? BW'(SW'(r_rem) - q_eff) : '0;

    assign time_sum = TW'(r_time) + TW'(r_slice);
    assign time_sat = (time_sum > TW'(TIME_MAX)) ? TIME_MAX : time_sum[TIME_W-1:0];
    assign sp_next  = ((CW'(r_sel) + CW'(1)) >= r_count) ? '0 : r_sel + IW'(1);

    assign wt_next = (r_fin && (WW'(r_time) >= WW'(r_bur)))
                     ? TIME_W'(WW'(r_time) - WW'(r_bur)) : '0;

    assign tat_sum  = UW'(r_wt) + UW'(r_bur);
    assign tat_next = !r_fin ? '0
                    : (tat_sum > UW'(TIME_MAX)) ? TIME_MAX : tat_sum[TIME_W-1:0];

    // waiting and turnaround are zero unless the slice finished the process
    assign wsum_add  = S1W'(r_wsum) + S1W'(r_wt);
    assign tsum_add  = S1W'(r_tsum) + S1W'(r_tat);
    assign wsum_next = (wsum_add > S1W'(SUM_MAX)) ? SUM_MAX : wsum_add[SUM_W-1:0];
    assign tsum_next = (tsum_add > S1W'(SUM_MAX)) ? SUM_MAX : tsum_add[SUM_W-1:0];

    always_comb begin
        n_out_status = ST_NONE;
        n_out_index  = '0;
        n_out_time   = r_time;
        n_out_fin    = 1'b0;
        n_out_wt     = '0;
        n_out_tat    = '0;
        n_out_wsum   = r_wsum;
        n_out_tsum   = r_tsum;
        case (r_op)
            OP_LOAD: begin
                if (table_full) begin
                    n_out_status = ST_FULL;
                end else begin
                    n_out_status = ST_LOADED;
                    n_out_index  = count_idx;
                end
            end
            OP_CLEAR: begin
                n_out_status = ST_CLEARED;
                n_out_time   = '0;
                n_out_wsum   = '0;
                n_out_tsum   = '0;
            end
            OP_STEP: begin
                if (r_found) begin
                    n_out_status = ST_RUN;
                    n_out_index  = r_sel;
                    n_out_fin    = r_fin;
                    n_out_wt     = r_wt;
                    n_out_tat    = r_tat;
                    n_out_wsum   = wsum_next;
                    n_out_tsum   = tsum_next;
                end
            end
            default: begin
                n_out_status = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum   <= QUANTUM_RESET;
            r_count     <= '0;
            r_time      <= '0;
            r_sp        <= '0;
            r_wsum      <= '0;
            r_tsum      <= '0;
            r_left      <= '0;
            r_chk_v     <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_quantum <= i_cfg_wr_data;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.accept) begin
                r_found <= 1'b0;
                r_chk_v <= 1'b0;
                r_addr  <= scan_start;
                r_left  <= r_count;
            end

            if (i_cmd.scan) begin
                r_chk_v   <= issue;
                r_chk_idx <= r_addr;
                if (issue) begin
                    r_addr <= addr_next;
                    r_left <= r_left - CW'(1);
                end
                if (o_stat.found) begin
                    r_found <= 1'b1;
                    r_sel   <= r_chk_idx;
                    r_rem   <= rd_rem;
                    r_bur   <= rd_bur;
                end
            end

            if (i_cmd.slice) begin
                r_slice <= rem_gt ? q_eff : SW'(r_rem);
                r_fin   <= !rem_gt;
            end

            if (i_cmd.advance) begin
                r_time <= time_sat;
                r_sp   <= sp_next;
            end

            if (i_cmd.wait_t) begin
                r_wt <= wt_next;
            end

            if (i_cmd.turn) begin
                r_tat <= tat_next;
            end

            if (i_cmd.emit) begin
                r_out_status <= n_out_status;
                r_out_index  <= n_out_index;
                r_out_time   <= n_out_time;
                r_out_fin    <= n_out_fin;
                r_out_wt     <= n_out_wt;
                r_out_tat    <= n_out_tat;
                r_out_wsum   <= n_out_wsum;
                r_out_tsum   <= n_out_tsum;
                case (r_op)
                    OP_LOAD: begin
                        if (!table_full) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    OP_CLEAR: begin
                        r_count <= '0;
                        r_time  <= '0;
                        r_sp    <= '0;
                        r_wsum  <= '0;
                        r_tsum  <= '0;
                    end
                    OP_STEP: begin
                        if (r_found) begin
                            r_wsum <= wsum_next;
                            r_tsum <= tsum_next;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // item fields, latched at accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_operation;
            r_burst_in <= BW'(i_burst_len);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_process_index    = r_out_index;
    assign o_slice_end_time   = r_out_time;
    assign o_finished         = r_out_fin;
    assign o_waiting_time     = r_out_wt;
    assign o_turnaround_time  = r_out_tat;
    assign o_total_waiting    = r_out_wsum;
    assign o_total_turnaround = r_out_tsum;

endmodule

`default_nettype wire

[rtl/round_robin_slice_scheduler.sv]
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_stall   i_operation, i_burst_len
// result    out        o_out_valid / i_out_stall o_status .. o_total_turnaround
// config    in         i_cfg_wr_en               i_cfg_wr_data (quantum)
//
// Load, clear and the spare opcode go straight from accept to the result. A step
// scans from the saved start pointer to the first loaded process with work left,
// or over all loaded processes when none is pending, reading one entry per cycle
// (registered read), then the slice, time, waiting and turnaround states in turn.
// Synchronous active-low reset; no clearing pass, the fill count bounds the scan.
// A stalled result holds in the output register; the next word is accepted
// meanwhile and waits at its final cycle until the output register frees.
`default_nettype none

module round_robin_slice_scheduler import rrss_pkg::*; #(
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
    parameter int BURST_BITS    = DEF_BURST_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [QUANTUM_W-1:0]        i_cfg_wr_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [OP_W-1:0]             i_operation,
    input  wire logic [BURST_IN_W-1:0]       i_burst_len,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [STATUS_W-1:0]              o_status,
    output logic [$clog2(MAX_PROCESSES)-1:0] o_process_index,
    output logic [TIME_W-1:0]                o_slice_end_time,
    output logic                             o_finished,
    output logic [TIME_W-1:0]                o_waiting_time,
    output logic [TIME_W-1:0]                o_turnaround_time,
    output logic [SUM_W-1:0]                 o_total_waiting,
    output logic [SUM_W-1:0]                 o_total_turnaround
);

    t_cmd  cmd;
    t_stat stat;

    rrss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    rrss_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .BURST_BITS    (BURST_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_operation        (i_operation),
        .i_burst_len        (i_burst_len),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_process_index    (o_process_index),
        .o_slice_end_time   (o_slice_end_time),
        .o_finished         (o_finished),
        .o_waiting_time     (o_waiting_time),
        .o_turnaround_time  (o_turnaround_time),
        .o_total_waiting    (o_total_waiting),
        .o_total_turnaround (o_total_turnaround)
    );

endmodule

`default_nettype wire
